### rtl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// Sizes, register indexes, shared types and helpers of the im2col address
// generator.
// ----------------------------------------------------------------------------
package im2col_pkg;

    localparam int unsigned MAX_WIDTH    = 1024;
    localparam int unsigned MAX_HEIGHT   = 1024;
    localparam int unsigned MAX_CHANNELS = 512;
    localparam int unsigned MAX_KERNEL   = 16;
    localparam int unsigned MAX_STRIDE   = 16;
    localparam int unsigned PAD_X        = 1;
    localparam int unsigned PAD_Y        = 1;

    // configuration port
    localparam int unsigned NUM_REGS   = 7;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned REG_IMG_W  = 11;
    localparam int unsigned REG_CH_W   = 10;
    localparam int unsigned REG_KS_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_KERNEL_WIDTH  = 3'd3,
        REG_KERNEL_HEIGHT = 3'd4,
        REG_STRIDE_X      = 3'd5,
        REG_STRIDE_Y      = 3'd6
    } t_reg_idx;

    // effective register widths
    localparam int unsigned W_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_W  = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned K_W  = $clog2(MAX_KERNEL + 1);
    localparam int unsigned S_W  = $clog2(MAX_STRIDE + 1);

    // counters and coordinates
    localparam int unsigned XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned KC_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int unsigned CC_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int unsigned MAX_PAD = (PAD_X > PAD_Y) ? PAD_X : PAD_Y;
    localparam int unsigned POS_W =
        $clog2(MAX_DIM + 2 * MAX_PAD + MAX_STRIDE + MAX_KERNEL + 1);
    localparam int unsigned WH_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    // payload fields
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned ROW_W   = 21;
    localparam int unsigned COL_W   = 17;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = ((ADDR_W + ROW_W + COL_W + 7) / 8) * 8;
    localparam int unsigned USER_W  = 1;

    typedef struct packed {
        logic [W_W-1:0]    w;
        logic [H_W-1:0]    h;
        logic [CH_W-1:0]   ch;
        logic [K_W-1:0]    kw;
        logic [K_W-1:0]    kh;
        logic [S_W-1:0]    sx;
        logic [S_W-1:0]    sy;
        logic [WH_W-1:0]   wh;
        logic [ADDR_W-1:0] whc;
    } t_cfg;

    // one element of the unfolded matrix, padded coordinates
    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [CC_W-1:0]  chan;
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] dest_row;
        logic [COL_W-1:0] dest_col;
        logic             last;
    } t_elem;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              pad;
        logic [ROW_W-1:0]  dest_row;
        logic [COL_W-1:0]  dest_col;
        logic              last;
    } t_result;

    // zero reads as one, values above the bound saturate
    function automatic logic [CFG_DATA_W-1:0] f_eff(
        input logic [CFG_DATA_W-1:0] v,
        input int unsigned           hi
    );
        logic [CFG_DATA_W-1:0] r;
        if (v == '0) begin
            r = CFG_DATA_W'(1);
        end else if (32'(v) > hi) begin
            r = CFG_DATA_W'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/im2col_address_generator.sv
// ----------------------------------------------------------------------------
// im2col_address_generator
// Walks the im2col unfolding of one channel-major image, one element per
// advance request, and gives source address, padding flag and matrix place.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       image index
//  m_axis    out        m_axis_tvalid/tready       address, row, col, pad, last
//  cfg       in         i_cfg_we                   register index and value
//
//  one request per cycle while m_axis is not stalled; a result is registered
//  after each of padding check, row and plane offsets and batch offset
//  reset: registers read as 1, all counters at zero, no clearing pass needed
//  any configuration write restarts the walk from the first element
//  a stalled output first fills the free pipeline stages, then holds s_axis_tready low
//
module im2col_address_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [im2col_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] image_index
    input  logic [im2col_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] source_address, [52:32] dest_row, [69:53] dest_col, rest zero
    output logic [im2col_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] is_padding
    output logic [im2col_pkg::USER_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tlast
);
    import im2col_pkg::*;

    t_cfg    cfg;
    t_elem   elem;
    t_result res;
    logic    in_ready;
    logic    accept;

    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    im2col_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    im2col_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_clear (i_cfg_we),
        .i_adv   (accept),
        .i_idx   (s_axis_tdata[IDX_W-1:0]),
        .o_elem  (elem)
    );

    im2col_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_elem  (elem),
        .i_valid (s_axis_tvalid),
        .o_ready (in_ready),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = {(OUT_DATA_W - ADDR_W - ROW_W - COL_W)'(0),
                           res.dest_col, res.dest_row, res.addr};
    assign m_axis_tuser = USER_W'(res.pad);
    assign m_axis_tlast = res.last;

endmodule

### rtl/im2col_cfg.sv
// ----------------------------------------------------------------------------
// im2col_cfg
// Register file holding the effective configuration, plus the registered
// plane and image size products.
// ----------------------------------------------------------------------------
module im2col_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [im2col_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output im2col_pkg::t_cfg                 o_cfg
);
    import im2col_pkg::*;

    logic [W_W-1:0]    r_w;
    logic [H_W-1:0]    r_h;
    logic [CH_W-1:0]   r_ch;
    logic [K_W-1:0]    r_kw;
    logic [K_W-1:0]    r_kh;
    logic [S_W-1:0]    r_sx;
    logic [S_W-1:0]    r_sy;
    logic [WH_W-1:0]   r_wh;
    logic [ADDR_W-1:0] r_whc;

    logic [CFG_DATA_W-1:0] img_v;
    logic [CFG_DATA_W-1:0] ch_v;
    logic [CFG_DATA_W-1:0] ks_v;

    assign img_v = CFG_DATA_W'(i_cfg_data[REG_IMG_W-1:0]);
    assign ch_v  = CFG_DATA_W'(i_cfg_data[REG_CH_W-1:0]);
    assign ks_v  = CFG_DATA_W'(i_cfg_data[REG_KS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= W_W'(1);
            r_h   <= H_W'(1);
            r_ch  <= CH_W'(1);
            r_kw  <= K_W'(1);
            r_kh  <= K_W'(1);
            r_sx  <= S_W'(1);
            r_sy  <= S_W'(1);
            r_wh  <= WH_W'(1);
            r_whc <= ADDR_W'(1);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:   r_w  <= W_W'(f_eff(img_v, MAX_WIDTH));
                    REG_IMAGE_HEIGHT:  r_h  <= H_W'(f_eff(img_v, MAX_HEIGHT));
                    REG_CHANNEL_COUNT: r_ch <= CH_W'(f_eff(ch_v, MAX_CHANNELS));
                    REG_KERNEL_WIDTH:  r_kw <= K_W'(f_eff(ks_v, MAX_KERNEL));
                    REG_KERNEL_HEIGHT: r_kh <= K_W'(f_eff(ks_v, MAX_KERNEL));
                    REG_STRIDE_X:      r_sx <= S_W'(f_eff(ks_v, MAX_STRIDE));
                    REG_STRIDE_Y:      r_sy <= S_W'(f_eff(ks_v, MAX_STRIDE));
                    default: ;
                endcase
            end
            // r_wh is registered from the sizes, r_whc from r_wh and the channel count
            r_wh  <= WH_W'(WH_W'(r_w) * WH_W'(r_h));
            r_whc <= ADDR_W'(r_wh) * ADDR_W'(r_ch);
        end
    end

    assign o_cfg = '{w: r_w, h: r_h, ch: r_ch, kw: r_kw, kh: r_kh,
                     sx: r_sx, sy: r_sy, wh: r_wh, whc: r_whc};

endmodule

### rtl/im2col_seq.sv
// ----------------------------------------------------------------------------
// im2col_seq
// Incremental position counters: output position, kernel offset, channel,
// destination row and column, stepped once per accepted request.
// ----------------------------------------------------------------------------
module im2col_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  im2col_pkg::t_cfg            i_cfg,
    input  logic                        i_clear,
    input  logic                        i_adv,
    input  logic [im2col_pkg::IDX_W-1:0] i_idx,
    output im2col_pkg::t_elem           o_elem
);
    import im2col_pkg::*;

    localparam int unsigned KS = K_W + 1;
    localparam int unsigned CS = CH_W + 1;

    logic [POS_W-1:0] r_base_x, n_base_x;
    logic [POS_W-1:0] r_base_y, n_base_y;
    logic [KC_W-1:0]  r_kx, n_kx;
    logic [KC_W-1:0]  r_ky, n_ky;
    logic [CC_W-1:0]  r_chan, n_chan;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_drow, n_drow;

    logic [POS_W-1:0] pw;
    logic [POS_W-1:0] ph;
    logic wrap_x, wrap_y, wrap_kx, wrap_ky, wrap_c, wrap_col;

    assign pw = POS_W'(i_cfg.w) + POS_W'(2 * PAD_X);
    assign ph = POS_W'(i_cfg.h) + POS_W'(2 * PAD_Y);

    // base_* is output position times stride, so the next window end is base + s + k
    assign wrap_x  = (r_base_x + POS_W'(i_cfg.sx) + POS_W'(i_cfg.kw)) > pw;
    assign wrap_y  = (r_base_y + POS_W'(i_cfg.sy) + POS_W'(i_cfg.kh)) > ph;
    assign wrap_kx = (KS'(r_kx) + KS'(1)) >= KS'(i_cfg.kw);
    assign wrap_ky = (KS'(r_ky) + KS'(1)) >= KS'(i_cfg.kh);
    assign wrap_c  = (CS'(r_chan) + CS'(1)) >= CS'(i_cfg.ch);
    assign wrap_col = wrap_kx && wrap_ky && wrap_c;

    always_comb begin
        n_base_x = r_base_x;
        n_base_y = r_base_y;
        n_kx     = r_kx;
        n_ky     = r_ky;
        n_chan   = r_chan;
        n_col    = r_col;
        n_drow   = r_drow;
        if (i_clear) begin
            n_base_x = '0;
            n_base_y = '0;
            n_kx     = '0;
            n_ky     = '0;
            n_chan   = '0;
            n_col    = '0;
            n_drow   = '0;
        end else if (i_adv) begin
            if (!wrap_x) begin
                n_base_x = r_base_x + POS_W'(i_cfg.sx);
                n_drow   = r_drow + ROW_W'(1);
            end else begin
                n_base_x = '0;
                if (!wrap_y) begin
                    n_base_y = r_base_y + POS_W'(i_cfg.sy);
                    n_drow   = r_drow + ROW_W'(1);
                end else begin
                    n_base_y = '0;
                    n_drow   = '0;
                    if (wrap_col) begin
                        n_col  = '0;
                        n_kx   = '0;
                        n_ky   = '0;
                        n_chan = '0;
                    end else begin
                        n_col = r_col + COL_W'(1);
                        if (!wrap_kx) begin
                            n_kx = r_kx + KC_W'(1);
                        end else begin
                            n_kx = '0;
                            if (!wrap_ky) begin
                                n_ky = r_ky + KC_W'(1);
                            end else begin
                                n_ky   = '0;
                                n_chan = r_chan + CC_W'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_kx     <= '0;
            r_ky     <= '0;
            r_chan   <= '0;
            r_col    <= '0;
            r_drow   <= '0;
        end else begin
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
            r_kx     <= n_kx;
            r_ky     <= n_ky;
            r_chan   <= n_chan;
            r_col    <= n_col;
            r_drow   <= n_drow;
        end
    end

    assign o_elem = '{px: r_base_x + POS_W'(r_kx),
                      py: r_base_y + POS_W'(r_ky),
                      chan: r_chan,
                      idx: i_idx,
                      dest_row: r_drow,
                      dest_col: r_col,
                      last: wrap_x && wrap_y && wrap_col};

endmodule

### rtl/im2col_addr.sv
// ----------------------------------------------------------------------------
// im2col_addr
// Three-stage address pipeline: padding check, row and plane offsets, batch
// offset and final sum. Each stage holds until the next one is free.
// ----------------------------------------------------------------------------
module im2col_addr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  im2col_pkg::t_cfg  i_cfg,
    input  im2col_pkg::t_elem i_elem,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_ready,
    output logic              o_valid,
    output im2col_pkg::t_result o_res
);
    import im2col_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic ready1, ready2, ready3;

    // stage 1
    logic [YW-1:0]    r1_row;
    logic [XW-1:0]    r1_col;
    logic [CC_W-1:0]  r1_chan;
    logic             r1_pad;
    logic [IDX_W-1:0] r1_idx;
    logic [ROW_W-1:0] r1_drow;
    logic [COL_W-1:0] r1_dcol;
    logic             r1_last;
    // stage 2
    logic [ADDR_W-1:0] r2_rc;
    logic [ADDR_W-1:0] r2_cp;
    logic              r2_pad;
    logic [IDX_W-1:0]  r2_idx;
    logic [ROW_W-1:0]  r2_drow;
    logic [COL_W-1:0]  r2_dcol;
    logic              r2_last;
    // stage 3
    logic [ADDR_W-1:0] r3_addr;
    logic              r3_pad;
    logic [ROW_W-1:0]  r3_drow;
    logic [COL_W-1:0]  r3_dcol;
    logic              r3_last;

    logic s1_pad;

    assign ready3  = !r_v3 || i_ready;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    assign s1_pad = (i_elem.px < POS_W'(PAD_X))
                 || (i_elem.px >= POS_W'(i_cfg.w) + POS_W'(PAD_X))
                 || (i_elem.py < POS_W'(PAD_Y))
                 || (i_elem.py >= POS_W'(i_cfg.h) + POS_W'(PAD_Y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r1_row  <= YW'(i_elem.py - POS_W'(PAD_Y));
            r1_col  <= XW'(i_elem.px - POS_W'(PAD_X));
            r1_chan <= i_elem.chan;
            r1_pad  <= s1_pad;
            r1_idx  <= i_elem.idx;
            r1_drow <= i_elem.dest_row;
            r1_dcol <= i_elem.dest_col;
            r1_last <= i_elem.last;
        end
        if (ready2 && r_v1) begin
            r2_rc   <= ADDR_W'(r1_row) * ADDR_W'(i_cfg.w) + ADDR_W'(r1_col);
            r2_cp   <= ADDR_W'(r1_chan) * ADDR_W'(i_cfg.wh);
            r2_pad  <= r1_pad;
            r2_idx  <= r1_idx;
            r2_drow <= r1_drow;
            r2_dcol <= r1_dcol;
            r2_last <= r1_last;
        end
        if (ready3 && r_v2) begin
            // padding elements carry a zero address
            r3_addr <= r2_pad ? '0
                     : ADDR_W'(r2_idx) * i_cfg.whc + r2_cp + r2_rc;
            r3_pad  <= r2_pad;
            r3_drow <= r2_drow;
            r3_dcol <= r2_dcol;
            r3_last <= r2_last;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = '{addr: r3_addr, pad: r3_pad, dest_row: r3_drow,
                       dest_col: r3_dcol, last: r3_last};

endmodule

### rtl/im2col_chk.sv
// ----------------------------------------------------------------------------
// im2col_chk
// Port-level checks of the im2col address generator, bound to the top level.
// ----------------------------------------------------------------------------
module im2col_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [im2col_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [im2col_pkg::USER_W-1:0]     m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import im2col_pkg::*;

    // nothing in flight right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // padding elements carry a zero address
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[ADDR_W-1:0] == '0)
        else $error("padding element with nonzero address");

    // with the output stage empty the whole pipeline can take a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind im2col_address_generator im2col_chk u_im2col_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
